### design/ipv4fhg_pkg.sv
package ipv4fhg_pkg;

  localparam int unsigned MaxFragments = 64;
  localparam int unsigned FragShift    = $clog2(MaxFragments);

  localparam logic [15:0] HdrBytes      = 16'd20;
  localparam logic [15:0] MinPayload    = 16'd28;
  localparam logic [15:0] MtuReset      = 16'd1486;
  localparam logic [15:0] SegReset      = (MtuReset - HdrBytes) & ~16'd7;
  localparam logic [15:0] MfBit         = 16'h2000;
  localparam int unsigned DfBitPos      = 14;
  localparam int unsigned SizeLimitPos  = 15;
  localparam logic [7:0]  VerIhl        = 8'h45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHECK,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_SHORT,
    STAT_TOO_BIG,
    STAT_DF,
    STAT_SMALL,
    STAT_MANY
  } status_e;

  typedef struct packed {
    logic        load;
    status_e     status;
    logic [15:0] total_len;
    logic [15:0] frag_word;
    logic [15:0] data_offset;
    logic [15:0] data_len;
    logic        last;
  } beat_t;

endpackage

### design/ipv4fhg_csum.sv
module ipv4fhg_csum (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [7:0]  tos_i,
  input  logic [7:0]  ttl_i,
  input  logic [7:0]  proto_i,
  input  logic [15:0] ident_i,
  input  logic [31:0] src_i,
  input  logic [31:0] dst_i,
  input  logic [15:0] total_len_i,
  input  logic [15:0] frag_word_i,
  output logic [15:0] checksum_o
);
  import ipv4fhg_pkg::*;

  // Sum of the header words that stay fixed over all fragments of a packet.
  logic [18:0] base_q;
  logic [18:0] base_d;
  logic [19:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign base_d = 19'({VerIhl, tos_i}) + 19'(ident_i) + 19'({ttl_i, proto_i})
                + 19'(src_i[31:16]) + 19'(src_i[15:0])
                + 19'(dst_i[31:16]) + 19'(dst_i[15:0]);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      base_q <= base_d;
    end
  end

  assign sum   = 20'(base_q) + 20'(total_len_i) + 20'(frag_word_i);
  assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign checksum_o = ~fold2;

endmodule

### design/ipv4fhg_seq.sv
module ipv4fhg_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                gating_i,
  input  logic [15:0]         buffer_bytes_i,
  input  logic [15:0]         hdr_total_len_i,
  input  logic [15:0]         hdr_ident_i,
  input  logic [15:0]         hdr_frag_word_i,
  input  logic [15:0]         mtu_i,
  input  logic [15:0]         seg_i,
  input  logic                small_i,
  input  logic                slot_free_i,
  output logic                base_load_o,
  output logic [15:0]         ident_o,
  output ipv4fhg_pkg::beat_t  beat_o
);
  import ipv4fhg_pkg::*;

  state_e      state_q, state_d;
  logic        gating_q;
  logic [15:0] buf_q, htlen_q, hid_q, hfw_q;
  logic [15:0] len_q, id_q, next_ident_q, off_q, rem_q;
  logic        short_q, unfrag_q;
  status_e     status_q, status_d;
  logic        accept, final_beat, fits, many, emit_load;
  logic [15:0] dlen, piece;
  logic [21:0] seg_cap;

  assign accept = in_valid_i && in_ready_o;
  assign fits   = len_q <= mtu_i;
  assign dlen   = len_q - HdrBytes;
  // More than the fragment cap when the payload exceeds cap * segment size.
  assign seg_cap = {seg_i, FragShift'(0)};
  assign many    = 22'(dlen) > seg_cap;

  always_comb begin
    if (short_q) begin
      status_d = STAT_SHORT;
    end else if (len_q[SizeLimitPos]) begin
      status_d = STAT_TOO_BIG;
    end else if (fits) begin
      status_d = STAT_OK;
    end else if (hfw_q[DfBitPos]) begin
      status_d = STAT_DF;
    end else if (small_i) begin
      status_d = STAT_SMALL;
    end else if (many) begin
      status_d = STAT_MANY;
    end else begin
      status_d = STAT_OK;
    end
  end

  assign final_beat = (status_q != STAT_OK) || unfrag_q || (rem_q <= seg_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LEN;
      ST_LEN:   state_d = ST_CHECK;
      ST_CHECK: state_d = ST_EMIT;
      ST_EMIT:  if (slot_free_i && final_beat) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    base_load_o = 1'b0;
    emit_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o  = 1'b1;
      ST_LEN:   ;
      ST_CHECK: base_load_o = 1'b1;
      ST_EMIT:  emit_load   = slot_free_i;
      default:  ;
    endcase
  end

  assign piece = final_beat ? rem_q : seg_i;

  always_comb begin
    beat_o.load   = emit_load;
    beat_o.status = status_q;
    beat_o.last   = final_beat;
    if (status_q != STAT_OK) begin
      beat_o.total_len   = '0;
      beat_o.frag_word   = '0;
      beat_o.data_offset = '0;
      beat_o.data_len    = '0;
    end else begin
      beat_o.total_len   = unfrag_q ? len_q : piece + HdrBytes;
      beat_o.frag_word   = {3'b000, off_q[15:3]} | (final_beat ? 16'h0000 : MfBit);
      beat_o.data_offset = off_q;
      beat_o.data_len    = piece;
    end
  end

  assign ident_o = id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      next_ident_q <= '0;
    end else begin
      state_q <= state_d;
      // Advance the id only for packets with OK status that take the generated id.
      if (state_q == ST_CHECK && status_d == STAT_OK && !gating_q) begin
        next_ident_q <= next_ident_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      gating_q <= gating_i;
      buf_q    <= buffer_bytes_i;
      htlen_q  <= hdr_total_len_i;
      hid_q    <= hdr_ident_i;
      hfw_q    <= hdr_frag_word_i;
    end
    if (state_q == ST_LEN) begin
      short_q <= gating_q && (htlen_q > buf_q);
      len_q   <= (gating_q && (htlen_q < buf_q)) ? htlen_q : buf_q;
      id_q    <= gating_q ? hid_q : next_ident_q;
    end
    if (state_q == ST_CHECK) begin
      status_q <= status_d;
      unfrag_q <= fits;
      off_q    <= '0;
      rem_q    <= (len_q >= HdrBytes) ? dlen : '0;
    end
    if (emit_load && !final_beat) begin
      off_q <= off_q + seg_i;
      rem_q <= rem_q - seg_i;
    end
  end

  a_ident_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_ident_q != $past(next_ident_q)) |-> (next_ident_q == $past(next_ident_q) + 16'd1))
    else $error("identification counter jumped");

endmodule

### design/ipv4_fragment_header_generator.sv
// IPv4 output header generator with fragmentation.
// Input channel (in_valid_i / in_ready_o) takes one packet descriptor per beat;
// output channel (out_valid_o / out_ready_i) gives one header per beat, with
// last_o high on the final header of a descriptor. An error gives a single
// beat with a nonzero status_o, last_o high and all other fields zero.
// The length limit register is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle; the block leaves it unchecked.
// It resets to 1486. A descriptor is accepted only in idle. The setup states
// ST_LEN (length trim) and ST_CHECK (checks and checksum base) follow, and
// then one header is loaded into the output register per cycle while the
// receiver takes them; the next descriptor waits until the last header is loaded.
// The segment step adder and the checksum folder are reused for every
// fragment. The output register holds a beat while out_ready_i is low and the
// sequencer waits. Reset returns to idle, clears the identification counter
// and empties the output register.
module ipv4_fragment_header_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        gating_i,
  input  logic [7:0]  ttl_arg_i,
  input  logic [15:0] buffer_bytes_i,
  input  logic [7:0]  hdr_tos_i,
  input  logic [15:0] hdr_total_len_i,
  input  logic [15:0] hdr_ident_i,
  input  logic [15:0] hdr_frag_word_i,
  input  logic [7:0]  hdr_ttl_i,
  input  logic [7:0]  hdr_proto_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  out_tos_o,
  output logic [7:0]  out_ttl_o,
  output logic [15:0] out_total_len_o,
  output logic [15:0] out_ident_o,
  output logic [15:0] out_frag_word_o,
  output logic [15:0] out_checksum_o,
  output logic [15:0] data_offset_o,
  output logic [15:0] data_len_o,
  output logic        last_o
);
  import ipv4fhg_pkg::*;

  logic [15:0] mtu_q, seg_q;
  logic        small_q;
  logic        accept, slot_free, base_load, is_err;
  logic [7:0]  tos_q, ttl_q, proto_q;
  logic [31:0] src_q, dst_q;
  logic [15:0] ident, checksum;
  beat_t       beat;

  logic        out_valid_q;
  status_e     status_q;
  logic [7:0]  out_tos_q, out_ttl_q;
  logic [15:0] out_total_len_q, out_ident_q, out_frag_word_q, out_checksum_q;
  logic [15:0] data_offset_q, data_len_q;
  logic        last_q;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign is_err    = beat.status != STAT_OK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q   <= MtuReset;
      seg_q   <= SegReset;
      small_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mtu_q <= cfg_wdata_i;
      end
      // Segment size: payload area rounded down to whole 8-byte units.
      seg_q   <= (mtu_q - HdrBytes) & ~16'd7;
      small_q <= mtu_q < MinPayload;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tos_q   <= gating_i ? hdr_tos_i : 8'h00;
      ttl_q   <= gating_i ? hdr_ttl_i : ttl_arg_i;
      proto_q <= hdr_proto_i;
      src_q   <= src_addr_i;
      dst_q   <= dst_addr_i;
    end
  end

  ipv4fhg_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .gating_i        (gating_i),
    .buffer_bytes_i  (buffer_bytes_i),
    .hdr_total_len_i (hdr_total_len_i),
    .hdr_ident_i     (hdr_ident_i),
    .hdr_frag_word_i (hdr_frag_word_i),
    .mtu_i           (mtu_q),
    .seg_i           (seg_q),
    .small_i         (small_q),
    .slot_free_i     (slot_free),
    .base_load_o     (base_load),
    .ident_o         (ident),
    .beat_o          (beat)
  );

  ipv4fhg_csum u_csum (
    .clk_i       (clk_i),
    .load_i      (base_load),
    .tos_i       (tos_q),
    .ttl_i       (ttl_q),
    .proto_i     (proto_q),
    .ident_i     (ident),
    .src_i       (src_q),
    .dst_i       (dst_q),
    .total_len_i (beat.total_len),
    .frag_word_i (beat.frag_word),
    .checksum_o  (checksum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat.load) begin
      status_q        <= beat.status;
      out_tos_q       <= is_err ? 8'h00 : tos_q;
      out_ttl_q       <= is_err ? 8'h00 : ttl_q;
      out_total_len_q <= beat.total_len;
      out_ident_q     <= is_err ? 16'h0000 : ident;
      out_frag_word_q <= beat.frag_word;
      out_checksum_q  <= is_err ? 16'h0000 : checksum;
      data_offset_q   <= beat.data_offset;
      data_len_q      <= beat.data_len;
      last_q          <= beat.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign out_tos_o       = out_tos_q;
  assign out_ttl_o       = out_ttl_q;
  assign out_total_len_o = out_total_len_q;
  assign out_ident_o     = out_ident_q;
  assign out_frag_word_o = out_frag_word_q;
  assign out_checksum_o  = out_checksum_q;
  assign data_offset_o   = data_offset_q;
  assign data_len_o      = data_len_q;
  assign last_o          = last_q;

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (last_o && out_total_len_o == 16'h0000))
    else $error("error beat not final or carries a length");

  a_mf_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_OK) |-> (out_frag_word_o[13] == !last_o))
    else $error("more-fragments flag disagrees with last");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !beat.load)
    else $error("output register overwritten while stalled");

  a_busy_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat.load |-> !in_ready_o)
    else $error("input open while headers are being emitted");

endmodule
